/* hdl/pic_pkg.sv */
// pic_pkg: widths, codes, reset values and shared types for the isolation cone sums
// no dependencies; imported by every module of the block

package pic_pkg;

  localparam int SUM_BITS_DEF = 24;
  localparam int NUM_SUMS     = 8;
  localparam int NUM_CLS      = 4;
  localparam int OUT_W        = 24;
  localparam int PT_W         = 16;
  localparam int KT_W         = 24;
  localparam int RAD_W        = 11;
  localparam int DZ_W         = 16;
  localparam int DZ_CUT_W     = 15;
  localparam int ETA_W        = 12;
  localparam int PHI_W        = 11;
  localparam int PDG_W        = 24;
  localparam int PV_W         = 2;
  localparam int DETA_SQ_W    = 24;
  localparam int DPHI_SQ_W    = 21;
  localparam int DR2_W        = 25;
  localparam int RAD_SQ_W     = 2 * RAD_W;
  localparam int Q_DEPTH      = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  localparam logic [PDG_W-1:0] PDG_CHARGED     = 24'd211;
  localparam logic [PDG_W-1:0] PDG_NEUTRAL_HAD = 24'd130;
  localparam logic [PDG_W-1:0] PDG_PHOTON      = 24'd22;
  localparam logic [PV_W-1:0]  PV_LEVEL_MIN    = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_ISO_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PV_DZ_CUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MINI_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MINI_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MINI_KT    = 3'd4;

  localparam logic [RAD_W-1:0]    ISO_RADIUS_RST = 11'd98;
  localparam logic [DZ_CUT_W-1:0] PV_DZ_CUT_RST  = 15'd102;
  localparam logic [RAD_W-1:0]    MINI_MIN_RST   = 11'd16;
  localparam logic [RAD_W-1:0]    MINI_MAX_RST   = 11'd65;
  localparam logic [KT_W-1:0]     MINI_KT_RST    = 24'd204800;

  // class codes double as the sum index within one cone
  typedef enum logic [2:0] {
    CLS_CH   = 3'd0,
    CLS_NH   = 3'd1,
    CLS_PH   = 3'd2,
    CLS_PU   = 3'd3,
    CLS_NONE = 3'd4
  } cls_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_DIV,
    BK_FIN
  } bk_state_t;

  typedef struct packed {
    logic [PT_W-1:0]  ref_pt;
    logic [PT_W-1:0]  cand_pt;
    logic [DR2_W-1:0] dr2;
    logic             in_fixed;
    cls_t             cls;
    logic             last;
  } qent_t;

  typedef struct packed {
    logic [RAD_W-1:0] min_radius;
    logic [RAD_W-1:0] max_radius;
    logic [KT_W-1:0]  kt_scale;
  } mini_cfg_t;

  typedef struct packed {
    logic dividing;
    logic pop;
    logic pop_last;
  } bk_stat_t;

endpackage

/* hdl/pic_front.sv */
// pic_front: accepts candidates, classifies them and computes dr2 and the fixed cone test
// depends on pic_pkg; feeds pic_queue

module pic_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pic_pkg::ETA_W-1:0]     in_ref_eta,
  input  logic signed [pic_pkg::PHI_W-1:0]     in_ref_phi,
  input  logic        [pic_pkg::PT_W-1:0]      in_ref_pt,
  input  logic signed [pic_pkg::ETA_W-1:0]     in_cand_eta,
  input  logic signed [pic_pkg::PHI_W-1:0]     in_cand_phi,
  input  logic        [pic_pkg::PT_W-1:0]      in_cand_pt,
  input  logic        [pic_pkg::PDG_W-1:0]     in_cand_abs_pdg,
  input  logic        [pic_pkg::PV_W-1:0]      in_cand_pv_level,
  input  logic signed [pic_pkg::DZ_W-1:0]      in_cand_dz,
  input  logic                                 in_is_self,
  input  logic                                 in_last,
  input  logic        [pic_pkg::RAD_W-1:0]     iso_radius,
  input  logic        [pic_pkg::DZ_CUT_W-1:0]  dz_cut,
  input  logic                                 q_full,
  output logic                                 push,
  output pic_pkg::qent_t                       push_ent
);
  import pic_pkg::*;

  logic                      adv;
  logic signed [ETA_W:0]     deta;
  logic signed [PHI_W-1:0]   dphi;
  logic        [DZ_W-1:0]    adz;
  logic                      from_pv;
  cls_t                      cls;

  logic                      s1_vld_r;
  logic signed [ETA_W:0]     s1_deta_r;
  logic signed [PHI_W-1:0]   s1_dphi_r;
  logic        [PT_W-1:0]    s1_ref_pt_r;
  logic        [PT_W-1:0]    s1_pt_r;
  cls_t                      s1_cls_r;
  logic                      s1_last_r;

  logic signed [2*ETA_W+1:0] deta_prod;
  logic signed [2*PHI_W-1:0] dphi_prod;

  logic                      s2_vld_r;
  logic        [DETA_SQ_W-1:0] s2_deta_sq_r;
  logic        [DPHI_SQ_W-1:0] s2_dphi_sq_r;
  logic        [PT_W-1:0]    s2_ref_pt_r;
  logic        [PT_W-1:0]    s2_pt_r;
  cls_t                      s2_cls_r;
  logic                      s2_last_r;

  logic        [RAD_SQ_W-1:0] rc_sq_r;
  logic        [DR2_W-1:0]   dr2;

  // the whole front holds while its last stage waits on a full queue
  assign adv      = !(s2_vld_r && q_full);
  assign in_ready = adv;

  assign deta = {in_cand_eta[ETA_W-1], in_cand_eta} - {in_ref_eta[ETA_W-1], in_ref_eta};
  assign dphi = in_cand_phi - in_ref_phi;
  assign adz  = in_cand_dz[DZ_W-1] ? DZ_W'(-in_cand_dz) : in_cand_dz;
  assign from_pv = (in_cand_pv_level > PV_LEVEL_MIN) || (adz < DZ_W'(dz_cut));

  always_comb begin
    if (in_is_self) begin
      cls = CLS_NONE;
    end else if (in_cand_abs_pdg == PDG_CHARGED) begin
      cls = from_pv ? CLS_CH : CLS_PU;
    end else if (in_cand_abs_pdg == PDG_NEUTRAL_HAD) begin
      cls = CLS_NH;
    end else if (in_cand_abs_pdg == PDG_PHOTON) begin
      cls = CLS_PH;
    end else begin
      cls = CLS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_deta_r   <= deta;
      s1_dphi_r   <= dphi;
      s1_ref_pt_r <= in_ref_pt;
      s1_pt_r     <= in_cand_pt;
      s1_cls_r    <= cls;
      s1_last_r   <= in_last;
    end
  end

  assign deta_prod = s1_deta_r * s1_deta_r;
  assign dphi_prod = s1_dphi_r * s1_dphi_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_deta_sq_r <= deta_prod[DETA_SQ_W-1:0];
      s2_dphi_sq_r <= dphi_prod[DPHI_SQ_W-1:0];
      s2_ref_pt_r  <= s1_ref_pt_r;
      s2_pt_r      <= s1_pt_r;
      s2_cls_r     <= s1_cls_r;
      s2_last_r    <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    rc_sq_r <= iso_radius * iso_radius;
  end

  assign dr2 = DR2_W'(s2_deta_sq_r) + DR2_W'(s2_dphi_sq_r);

  assign push              = s2_vld_r && !q_full;
  assign push_ent.ref_pt   = s2_ref_pt_r;
  assign push_ent.cand_pt  = s2_pt_r;
  assign push_ent.dr2      = dr2;
  assign push_ent.in_fixed = dr2 < DR2_W'(rc_sq_r);
  assign push_ent.cls      = s2_cls_r;
  assign push_ent.last     = s2_last_r;

endmodule

/* hdl/pic_queue.sv */
// pic_queue: short fifo of classified candidates between front and back
// depends on pic_pkg

module pic_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pic_pkg::qent_t push_ent,
  output logic           full,
  input  logic           pop,
  output logic           head_vld,
  output pic_pkg::qent_t head
);
  import pic_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  qent_t              mem_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;

  assign full     = (cnt_r == CNT_W'(Q_DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head     = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

/* hdl/pic_back.sv */
// pic_back: mini cone radius (serial divider with a one-entry cache), saturating sums, result register
// depends on pic_pkg; drains pic_queue

module pic_back #(
  parameter int SUM_BITS = pic_pkg::SUM_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  pic_pkg::mini_cfg_t                              mini_cfg,
  input  logic                                            cfg_wr,
  input  logic                                            head_vld,
  input  pic_pkg::qent_t                                  head,
  output logic                                            pop,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic [pic_pkg::NUM_SUMS-1:0][pic_pkg::OUT_W-1:0] out_sums,
  output pic_pkg::bk_stat_t                               stat
);
  import pic_pkg::*;

  localparam int CNT_W = $clog2(KT_W);

  bk_state_t              state_r;
  bk_state_t              state_nxt;

  logic                   hit;
  logic                   out_free;
  logic                   div_load;
  logic                   div_step;
  logic                   fin;

  logic [PT_W-1:0]        cache_pt_r;
  logic                   cache_vld_r;
  logic [RAD_SQ_W-1:0]    mr_sq_r;

  logic [KT_W-1:0]        dvd_r;
  logic [PT_W-1:0]        rem_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [PT_W:0]          sh;
  logic                   ge;

  logic [RAD_W-1:0]       mr_clip;
  logic [RAD_W-1:0]       mr;
  logic [RAD_SQ_W-1:0]    mr_sq;
  logic                   in_mini;

  logic [SUM_BITS-1:0]    sum_r   [NUM_SUMS];
  logic [SUM_BITS-1:0]    sum_nxt [NUM_SUMS];
  logic [NUM_SUMS-1:0][OUT_W-1:0] out_nxt;
  logic [NUM_SUMS-1:0][OUT_W-1:0] out_sums_r;
  logic                   out_vld_r;

  assign hit      = head_vld && cache_vld_r && (cache_pt_r == head.ref_pt);
  assign out_free = !out_vld_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_RUN: begin
        if (head_vld && !hit) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        state_nxt = BK_RUN;
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  always_comb begin
    div_load = 1'b0;
    div_step = 1'b0;
    fin      = 1'b0;
    pop      = 1'b0;
    unique case (state_r)
      BK_RUN: begin
        div_load = head_vld && !hit;
        pop      = hit && out_free;
      end
      BK_DIV: div_step = 1'b1;
      BK_FIN: fin = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // restoring division, one quotient bit per cycle; a zero divisor gives all ones
  assign sh = {rem_r, dvd_r[KT_W-1]};
  assign ge = sh >= {1'b0, cache_pt_r};

  always_ff @(posedge clk) begin
    if (div_load) begin
      dvd_r <= mini_cfg.kt_scale;
      rem_r <= '0;
      cnt_r <= CNT_W'(KT_W - 1);
    end else if (div_step) begin
      dvd_r <= {dvd_r[KT_W-2:0], ge};
      rem_r <= ge ? PT_W'(sh - {1'b0, cache_pt_r}) : sh[PT_W-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign mr_clip = (dvd_r < KT_W'(mini_cfg.max_radius)) ? dvd_r[RAD_W-1:0]
                                                        : mini_cfg.max_radius;
  assign mr      = (mr_clip < mini_cfg.min_radius) ? mini_cfg.min_radius : mr_clip;
  assign mr_sq   = mr * mr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_vld_r <= 1'b0;
    end else if (cfg_wr || div_load) begin
      cache_vld_r <= 1'b0;
    end else if (fin) begin
      cache_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      cache_pt_r <= head.ref_pt;
    end
    if (fin) begin
      mr_sq_r <= mr_sq;
    end
  end

  assign in_mini = head.dr2 < DR2_W'(mr_sq_r);

  for (genvar k = 0; k < NUM_SUMS; k++) begin : g_lane
    localparam int CLS_IDX = k % NUM_CLS;
    logic                en;
    logic [SUM_BITS:0]   add;
    logic [31:0]         wide;

    assign en  = ((k < NUM_CLS) ? head.in_fixed : in_mini) && (head.cls == cls_t'(CLS_IDX));
    assign add = {1'b0, sum_r[k]} + (SUM_BITS + 1)'(head.cand_pt);
    assign sum_nxt[k] = !en ? sum_r[k] : (add[SUM_BITS] ? '1 : add[SUM_BITS-1:0]);
    assign wide = 32'(sum_nxt[k]);
    assign out_nxt[k] = (wide > 32'(OUT_MAX)) ? OUT_MAX : wide[OUT_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sum_r[k] <= '0;
      end else if (pop) begin
        sum_r[k] <= head.last ? '0 : sum_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pop && head.last) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_sums_r <= out_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_sums      = out_sums_r;
  assign stat.dividing = (state_r == BK_DIV);
  assign stat.pop      = pop;
  assign stat.pop_last = pop && head.last;

endmodule

/* hdl/particle_isolation_cone_sums.sv */
// particle_isolation_cone_sums: top level with configuration registers and assertions
// depends on pic_pkg, pic_front, pic_queue, pic_back
//
// Candidates arrive one per beat on the in_ channel together with the reference track.
// Each one is classified and its squared distance to the track computed in a two-stage
// front, then queued (four entries) for the back, which adds its pt into four fixed-cone
// and four mini-cone saturating sums. The beat flagged in_last makes the eight sums
// appear as one out_ beat, held in an output register, and clears them.
// Throughput: one candidate per cycle while in_ref_pt repeats and out_valid is not stalled.
// The mini radius needs kt/ref_pt, taken by a bit-serial divider; its result is cached
// for the last ref_pt, so each new ref_pt value stalls the back for a detect step, 24
// divide steps and a clamp. A last candidate with a cached radius passes both front
// stages, the queue and the output register before it shows on out_valid. While out_valid
// waits on out_ready the back takes no candidate; the queue and front fill, then in_ready falls.
// cfg_ is always ready; the user must write registers only while idle, unenforced by the block.
// Reset (synchronous, rst_n low): sums zero, registers to defaults, queue and cache empty.

module particle_isolation_cone_sums #(
  parameter int SUM_BITS = pic_pkg::SUM_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [pic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [pic_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pic_pkg::ETA_W-1:0]     in_ref_eta,
  input  logic signed [pic_pkg::PHI_W-1:0]     in_ref_phi,
  input  logic        [pic_pkg::PT_W-1:0]      in_ref_pt,
  input  logic signed [pic_pkg::ETA_W-1:0]     in_cand_eta,
  input  logic signed [pic_pkg::PHI_W-1:0]     in_cand_phi,
  input  logic        [pic_pkg::PT_W-1:0]      in_cand_pt,
  input  logic        [pic_pkg::PDG_W-1:0]     in_cand_abs_pdg,
  input  logic        [pic_pkg::PV_W-1:0]      in_cand_pv_level,
  input  logic signed [pic_pkg::DZ_W-1:0]      in_cand_dz,
  input  logic                                 in_is_self,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [pic_pkg::OUT_W-1:0]     out_ch_iso,
  output logic        [pic_pkg::OUT_W-1:0]     out_nh_iso,
  output logic        [pic_pkg::OUT_W-1:0]     out_ph_iso,
  output logic        [pic_pkg::OUT_W-1:0]     out_pu_iso,
  output logic        [pic_pkg::OUT_W-1:0]     out_mini_ch_iso,
  output logic        [pic_pkg::OUT_W-1:0]     out_mini_nh_iso,
  output logic        [pic_pkg::OUT_W-1:0]     out_mini_ph_iso,
  output logic        [pic_pkg::OUT_W-1:0]     out_mini_pu_iso
);
  import pic_pkg::*;

  logic [RAD_W-1:0]    iso_radius_r;
  logic [DZ_CUT_W-1:0] dz_cut_r;
  mini_cfg_t           mini_cfg_r;
  logic                cfg_wr;

  logic                q_full;
  logic                push;
  qent_t               push_ent;
  logic                pop;
  logic                head_vld;
  qent_t               head;
  bk_stat_t            bk_stat;
  logic [NUM_SUMS-1:0][OUT_W-1:0] out_sums;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_radius_r          <= ISO_RADIUS_RST;
      dz_cut_r              <= PV_DZ_CUT_RST;
      mini_cfg_r.min_radius <= MINI_MIN_RST;
      mini_cfg_r.max_radius <= MINI_MAX_RST;
      mini_cfg_r.kt_scale   <= MINI_KT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_ISO_RADIUS: iso_radius_r          <= cfg_data[RAD_W-1:0];
        REG_PV_DZ_CUT:  dz_cut_r              <= cfg_data[DZ_CUT_W-1:0];
        REG_MINI_MIN:   mini_cfg_r.min_radius <= cfg_data[RAD_W-1:0];
        REG_MINI_MAX:   mini_cfg_r.max_radius <= cfg_data[RAD_W-1:0];
        REG_MINI_KT:    mini_cfg_r.kt_scale   <= cfg_data[KT_W-1:0];
        default: ;
      endcase
    end
  end

  pic_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ref_eta       (in_ref_eta),
    .in_ref_phi       (in_ref_phi),
    .in_ref_pt        (in_ref_pt),
    .in_cand_eta      (in_cand_eta),
    .in_cand_phi      (in_cand_phi),
    .in_cand_pt       (in_cand_pt),
    .in_cand_abs_pdg  (in_cand_abs_pdg),
    .in_cand_pv_level (in_cand_pv_level),
    .in_cand_dz       (in_cand_dz),
    .in_is_self       (in_is_self),
    .in_last          (in_last),
    .iso_radius       (iso_radius_r),
    .dz_cut           (dz_cut_r),
    .q_full           (q_full),
    .push             (push),
    .push_ent         (push_ent)
  );

  pic_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (pop),
    .head_vld (head_vld),
    .head     (head)
  );

  pic_back #(
    .SUM_BITS (SUM_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mini_cfg  (mini_cfg_r),
    .cfg_wr    (cfg_wr),
    .head_vld  (head_vld),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sums  (out_sums),
    .stat      (bk_stat)
  );

  assign out_ch_iso      = out_sums[0];
  assign out_nh_iso      = out_sums[1];
  assign out_ph_iso      = out_sums[2];
  assign out_pu_iso      = out_sums[3];
  assign out_mini_ch_iso = out_sums[4];
  assign out_mini_nh_iso = out_sums[5];
  assign out_mini_ph_iso = out_sums[6];
  assign out_mini_pu_iso = out_sums[7];

  // a set may not end while the previous result is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !bk_stat.pop_last)
    else $error("result register overwritten while stalled");

  // nothing leaves the queue while the radius is being recomputed
  a_no_pop_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.dividing |-> !bk_stat.pop)
    else $error("candidate consumed during division");

  // the front only stalls on a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_full)
    else $error("front stalled without queue backpressure");

  // a result appears only the cycle after a set's last candidate is consumed
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_stat.pop_last))
    else $error("result without a last candidate");

endmodule
